>>> rtl/dfb_pkg.sv
// Shared types, constants and the CRC-16 byte update for the byte deframer.
package dfb_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CrcW = 16;
	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_FRAME  = 3'd1,
		PH_ESC    = 3'd2,
		PH_CRC_LO = 3'd3,
		PH_CRC_HI = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_CONTINUE = 2'd0,
		ST_DONE     = 2'd1,
		ST_INV_CHAR = 2'd2,
		ST_INV_CRC  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_CRC_ENABLE  = 3'd0,
		REG_CRC_INITIAL = 3'd1,
		REG_CRC_POLY    = 3'd2,
		REG_START_CODE  = 3'd3,
		REG_END_CODE    = 3'd4,
		REG_ESCAPE_CODE = 3'd5
	} reg_idx_t;

	localparam logic [CrcW-1:0] CrcInitialRst = 16'hFFFF;
	localparam logic [CrcW-1:0] CrcPolyRst = 16'h1021;
	localparam logic [ByteW-1:0] StartCodeRst = 8'h02;
	localparam logic [ByteW-1:0] EndCodeRst = 8'h03;
	localparam logic [ByteW-1:0] EscapeCodeRst = 8'h10;

	typedef struct packed {
		logic             crc_enable;
		logic [CrcW-1:0]  crc_initial;
		logic [CrcW-1:0]  crc_polynomial;
		logic [ByteW-1:0] start_code;
		logic [ByteW-1:0] end_code;
		logic [ByteW-1:0] escape_code;
	} cfg_t;

	typedef struct packed {
		logic             data_valid;
		logic [ByteW-1:0] data_byte;
		status_t          frame_status;
	} result_t;

	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] b, input logic [CrcW-1:0] poly);
		logic [CrcW-1:0] c;
		c = crc ^ {b, {(CrcW-ByteW){1'b0}}};
		for (int i = 0; i < ByteW; i++) begin
			if (c[CrcW-1]) begin
				c = {c[CrcW-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[CrcW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/dfb_cfg_regs.sv
// Configuration register file behind the APB-style port.
module dfb_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dfb_pkg::AddrW-1:0]  paddr,
	input  logic [dfb_pkg::DataW-1:0]  pwdata,
	output logic [dfb_pkg::DataW-1:0]  prdata,
	output dfb_pkg::cfg_t              cfg
);

	dfb_pkg::cfg_t cfg_q;
	dfb_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = dfb_pkg::reg_idx_t'(paddr[dfb_pkg::AddrW-1:2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_enable <= 1'b0;
			cfg_q.crc_initial <= dfb_pkg::CrcInitialRst;
			cfg_q.crc_polynomial <= dfb_pkg::CrcPolyRst;
			cfg_q.start_code <= dfb_pkg::StartCodeRst;
			cfg_q.end_code <= dfb_pkg::EndCodeRst;
			cfg_q.escape_code <= dfb_pkg::EscapeCodeRst;
		end else if (wr_en) begin
			case (idx)
				dfb_pkg::REG_CRC_ENABLE: cfg_q.crc_enable <= pwdata[0];
				dfb_pkg::REG_CRC_INITIAL: cfg_q.crc_initial <= pwdata[dfb_pkg::CrcW-1:0];
				dfb_pkg::REG_CRC_POLY: cfg_q.crc_polynomial <= pwdata[dfb_pkg::CrcW-1:0];
				dfb_pkg::REG_START_CODE: cfg_q.start_code <= pwdata[dfb_pkg::ByteW-1:0];
				dfb_pkg::REG_END_CODE: cfg_q.end_code <= pwdata[dfb_pkg::ByteW-1:0];
				dfb_pkg::REG_ESCAPE_CODE: cfg_q.escape_code <= pwdata[dfb_pkg::ByteW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			dfb_pkg::REG_CRC_ENABLE: prdata[0] = cfg_q.crc_enable;
			dfb_pkg::REG_CRC_INITIAL: prdata[dfb_pkg::CrcW-1:0] = cfg_q.crc_initial;
			dfb_pkg::REG_CRC_POLY: prdata[dfb_pkg::CrcW-1:0] = cfg_q.crc_polynomial;
			dfb_pkg::REG_START_CODE: prdata[dfb_pkg::ByteW-1:0] = cfg_q.start_code;
			dfb_pkg::REG_END_CODE: prdata[dfb_pkg::ByteW-1:0] = cfg_q.end_code;
			dfb_pkg::REG_ESCAPE_CODE: prdata[dfb_pkg::ByteW-1:0] = cfg_q.escape_code;
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/dfb_decode.sv
// Frame phase tracking, unescaping and running CRC-16 for one byte per beat.
module dfb_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [dfb_pkg::ByteW-1:0]   rx_byte,
	input  dfb_pkg::cfg_t               cfg,
	output dfb_pkg::result_t            result
);

	dfb_pkg::phase_t phase_q, phase_d;
	logic [dfb_pkg::CrcW-1:0] crc_q, crc_d;
	logic [dfb_pkg::ByteW-1:0] crc_lo_q, crc_lo_d;
	logic in_frame, esc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dfb_pkg::PH_IDLE;
			crc_q <= dfb_pkg::CrcInitialRst;
			crc_lo_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			crc_q <= crc_d;
			crc_lo_q <= crc_lo_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		crc_d = crc_q;
		crc_lo_d = crc_lo_q;
		result.data_valid = 1'b0;
		result.data_byte = '0;
		result.frame_status = dfb_pkg::ST_CONTINUE;
		in_frame = (phase_q == dfb_pkg::PH_FRAME);
		esc = (phase_q == dfb_pkg::PH_ESC);
		case (phase_q)
			dfb_pkg::PH_CRC_LO: begin
				crc_lo_d = rx_byte;
				phase_d = dfb_pkg::PH_CRC_HI;
			end
			dfb_pkg::PH_CRC_HI: begin
				result.frame_status = ({rx_byte, crc_lo_q} != crc_q) ?
					dfb_pkg::ST_INV_CRC : dfb_pkg::ST_DONE;
			end
			default: begin
				if (rx_byte == cfg.start_code) begin
					if (esc) begin
						result.data_valid = 1'b1;
						result.data_byte = rx_byte;
						phase_d = dfb_pkg::PH_FRAME;
					end else if (in_frame) begin
						result.frame_status = dfb_pkg::ST_INV_CHAR;
					end else begin
						phase_d = dfb_pkg::PH_FRAME;
					end
				end else if (rx_byte == cfg.end_code) begin
					if (esc) begin
						result.data_valid = 1'b1;
						result.data_byte = rx_byte;
						phase_d = dfb_pkg::PH_FRAME;
					end else if (in_frame) begin
						if (cfg.crc_enable) begin
							phase_d = dfb_pkg::PH_CRC_LO;
						end else begin
							result.frame_status = dfb_pkg::ST_DONE;
						end
					end else begin
						result.frame_status = dfb_pkg::ST_INV_CHAR;
					end
				end else if (rx_byte == cfg.escape_code) begin
					if (esc) begin
						result.data_valid = 1'b1;
						result.data_byte = rx_byte;
						phase_d = dfb_pkg::PH_FRAME;
					end else if (in_frame) begin
						phase_d = dfb_pkg::PH_ESC;
					end else begin
						result.frame_status = dfb_pkg::ST_INV_CHAR;
					end
				end else begin
					if (in_frame) begin
						result.data_valid = 1'b1;
						result.data_byte = rx_byte;
					end else begin
						result.frame_status = dfb_pkg::ST_INV_CHAR;
					end
				end
				if (cfg.crc_enable) begin
					crc_d = dfb_pkg::crc_byte(crc_q, rx_byte, cfg.crc_polynomial);
				end
			end
		endcase
		if (result.frame_status != dfb_pkg::ST_CONTINUE) begin
			phase_d = dfb_pkg::PH_IDLE;
			if (cfg.crc_enable) begin
				crc_d = cfg.crc_initial;
			end
		end
	end

endmodule

>>> rtl/dfb_out_buf.sv
// Result register with a skid entry so a new beat is taken while a result waits.
module dfb_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfb_pkg::result_t  push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output dfb_pkg::result_t  out_data
);

	logic main_valid_q, skid_valid_q;
	dfb_pkg::result_t main_q, skid_q;
	logic main_load;

	assign can_push = ~skid_valid_q;
	assign main_load = ~main_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_load) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_load) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data = main_q;

endmodule

>>> rtl/dle_framed_byte_deframer_top.sv
// Top level of the start/end/escape byte deframer with CRC-16 check.
//
// The input channel (in_valid, in_ready, rx_byte) takes one raw link byte per
// beat. Every accepted byte gives exactly one result beat on the output
// channel (out_valid, out_ready, data_valid, data_byte, frame_status).
// The frame phase and the running CRC are updated at the edge that accepts a
// byte, and the result is registered at that edge too. Throughput is one byte
// per cycle while in_ready is high; the unrolled eight-bit CRC update and the
// phase decode sit between the accepted byte and the result register.
// When the receiver stalls, one more result is held in a skid entry, and
// in_ready falls only while that entry is occupied.
// The APB-style port sets CRC enable, initial value, polynomial and the three
// code bytes; write it only while no beat is in flight.
// Reset clears both result entries, returns the phase to idle, loads the
// running CRC with the reset initial value and restores register defaults.
module dle_framed_byte_deframer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dfb_pkg::AddrW-1:0]  paddr,
	input  logic [dfb_pkg::DataW-1:0]  pwdata,
	output logic [dfb_pkg::DataW-1:0]  prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dfb_pkg::ByteW-1:0]  rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       data_valid,
	output logic [dfb_pkg::ByteW-1:0]  data_byte,
	output logic [1:0]                 frame_status
);

	dfb_pkg::cfg_t cfg;
	dfb_pkg::result_t result;
	dfb_pkg::result_t out_data;
	logic accept;

	assign pready = 1'b1;
	assign accept = in_valid & in_ready;

	dfb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	dfb_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cfg     (cfg),
		.result  (result)
	);

	dfb_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign data_valid = out_data.data_valid;
	assign data_byte = out_data.data_byte;
	assign frame_status = out_data.frame_status;

endmodule
